>>> src/pee_pkg.sv
// Shared types, character codes and helper functions for the dual-assignment
// parenthesized expression evaluator. No dependencies.
`timescale 1ns / 1ps

package pee_pkg;

  localparam int unsigned STACK_DEPTH = 32;

  localparam logic [7:0] CH_AND   = 8'h26;
  localparam logic [7:0] CH_OR    = 8'h7C;
  localparam logic [7:0] CH_XOR   = 8'h5E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  // Bit 0 is the lane with x=0, X=1; bit 1 is the lane with x=1, X=0.
  typedef logic [1:0] pair_t;

  localparam pair_t PAIR_ZERO  = 2'b00;
  localparam pair_t PAIR_ONE   = 2'b11;
  localparam pair_t PAIR_LOW_X = 2'b10;
  localparam pair_t PAIR_UP_X  = 2'b01;

  typedef enum logic [1:0] {
    OP_AND   = 2'd0,
    OP_OR    = 2'd1,
    OP_XOR   = 2'd2,
    OP_OTHER = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CLS_OPEN  = 2'd0,
    CLS_CLOSE = 2'd1,
    CLS_VALUE = 2'd2,
    CLS_OPER  = 2'd3
  } cls_e;

  typedef struct packed {
    cls_e  cls;
    pair_t val;
    op_e   op;
  } dec_t;

  typedef struct packed {
    logic  push;
    logic  reduce;
    logic  clear;
    pair_t data;
  } vstk_cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
    op_e  op;
  } ostk_cmd_t;

  function automatic dec_t decode_char(input logic [7:0] ch);
    dec_t d;
    d.cls = CLS_OPER;
    d.val = PAIR_ZERO;
    d.op  = OP_OTHER;
    case (ch)
      CH_ZERO: begin
        d.cls = CLS_VALUE;
        d.val = PAIR_ZERO;
      end
      CH_ONE: begin
        d.cls = CLS_VALUE;
        d.val = PAIR_ONE;
      end
      CH_LOW_X: begin
        d.cls = CLS_VALUE;
        d.val = PAIR_LOW_X;
      end
      CH_UP_X: begin
        d.cls = CLS_VALUE;
        d.val = PAIR_UP_X;
      end
      CH_OPEN:  d.cls = CLS_OPEN;
      CH_CLOSE: d.cls = CLS_CLOSE;
      CH_AND:   d.op = OP_AND;
      CH_OR:    d.op = OP_OR;
      CH_XOR:   d.op = OP_XOR;
      default:  d.op = OP_OTHER;
    endcase
    return d;
  endfunction

  function automatic pair_t combine(input op_e op, input pair_t a, input pair_t b);
    pair_t r;
    case (op)
      OP_AND:  r = a & b;
      OP_OR:   r = a | b;
      OP_XOR:  r = a ^ b;
      default: r = PAIR_ZERO;
    endcase
    return r;
  endfunction

endpackage

>>> src/pee_value_stack.sv
// Value pair stack: top and second entries in registers, all entries mirrored
// in a memory whose registered read port prefetches the third entry. Uses pee_pkg.
`timescale 1ns / 1ps

module pee_value_stack #(
  parameter int unsigned DEPTH = pee_pkg::STACK_DEPTH,
  localparam int unsigned CW   = $clog2(DEPTH + 1),
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pee_pkg::vstk_cmd_t  cmd_i,
  output logic [CW-1:0]       count_o,
  output pee_pkg::pair_t      top_o,
  output pee_pkg::pair_t      second_o
);

  logic [CW-1:0]  count_q, count_d;
  pee_pkg::pair_t top_q, top_d;
  pee_pkg::pair_t second_q, second_d;
  pee_pkg::pair_t rd_q;
  pee_pkg::pair_t stack_mem [DEPTH];
  logic [CW-1:0]  wr_full, rd_full;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic           wr_en;

  always_comb begin
    count_d  = count_q;
    top_d    = top_q;
    second_d = second_q;
    wr_en    = 1'b0;
    wr_full  = count_q;
    if (cmd_i.push) begin
      count_d  = count_q + CW'(1);
      top_d    = cmd_i.data;
      second_d = top_q;
      wr_en    = 1'b1;
    end else if (cmd_i.reduce) begin
      count_d  = count_q - CW'(1);
      top_d    = cmd_i.data;
      second_d = rd_q;
      wr_en    = 1'b1;
      wr_full  = count_q - CW'(2);
    end
    if (cmd_i.clear) begin
      count_d = '0;
    end
    rd_full = count_d - CW'(3);
  end

  assign wr_addr = wr_full[AW-1:0];
  assign rd_addr = rd_full[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    second_q <= second_d;
    if (wr_en) begin
      stack_mem[wr_addr] <= cmd_i.data;
    end
    rd_q <= stack_mem[rd_addr];
  end

  assign count_o  = count_q;
  assign top_o    = top_q;
  assign second_o = second_q;

endmodule

>>> src/pee_oper_stack.sv
// Operator stack: top entry in a register, all entries in a memory whose
// registered read port prefetches the entry below the top. Uses pee_pkg.
`timescale 1ns / 1ps

module pee_oper_stack #(
  parameter int unsigned DEPTH = pee_pkg::STACK_DEPTH,
  localparam int unsigned CW   = $clog2(DEPTH + 1),
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pee_pkg::ostk_cmd_t  cmd_i,
  output logic [CW-1:0]       count_o,
  output pee_pkg::op_e        top_o
);

  logic [CW-1:0] count_q, count_d;
  pee_pkg::op_e  top_q, top_d;
  pee_pkg::op_e  rd_q;
  pee_pkg::op_e  stack_mem [DEPTH];
  logic [CW-1:0] rd_full;
  logic [AW-1:0] wr_addr, rd_addr;

  always_comb begin
    count_d = count_q;
    top_d   = top_q;
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
      top_d   = cmd_i.op;
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
      top_d   = rd_q;
    end
    if (cmd_i.clear) begin
      count_d = '0;
    end
    rd_full = count_d - CW'(2);
  end

  assign wr_addr = count_q[AW-1:0];
  assign rd_addr = rd_full[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (cmd_i.push) begin
      stack_mem[wr_addr] <= cmd_i.op;
    end
    rd_q <= stack_mem[rd_addr];
  end

  assign count_o = count_q;
  assign top_o   = top_q;

endmodule

>>> src/paren_expr_dual_evaluator_unit.sv
// Top level of the dual-assignment parenthesized expression evaluator.
// Depends on pee_pkg, pee_value_stack and pee_oper_stack.
//
// Usage: the slave stream carries one character per item in s_axis_tdata_i,
// with s_axis_tlast_i marking the final character of an expression. Operands
// are 0, 1, x and X; '(' is ignored; ')' applies the newest operator to the two
// newest values; any other character is pushed as an operator.
// Only the final character of an expression produces a result item on the
// master stream. The result holds the top value under x=0, X=1 and under
// x=1, X=0, their difference, and a malformed flag for stack underflow,
// overflow or an empty value stack.
// Throughput is one character per cycle, set by the stack top registers,
// which are rewritten every cycle. A final character is held in the input
// register, and its result goes to the result register on the master side.
// When the master side stalls, non-final characters keep flowing into the
// stacks; a final character waits in the input register until the result
// register frees up. Reset empties both stacks and the error flag and
// leaves both streams idle.
`timescale 1ns / 1ps

module paren_expr_dual_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = pee_pkg::STACK_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] char_code
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o   // [0] result_differs, [1] value_x_low,
                                      // [2] value_x_high, [3] malformed, [7:4] zero
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic                in_valid_q;
  logic [7:0]          char_q;
  logic                last_q;
  logic                err_q, err_d;
  logic                out_valid_q;
  logic [3:0]          out_data_q, out_data_d;
  logic                advance;
  logic                err_now;
  pee_pkg::dec_t       dec;
  pee_pkg::vstk_cmd_t  vcmd;
  pee_pkg::ostk_cmd_t  ocmd;
  logic [CW-1:0]       v_count, o_count, nv_count;
  pee_pkg::pair_t      v_top, v_second, nv_top, merged;
  pee_pkg::op_e        o_top;
  logic                bad;

  assign advance = in_valid_q && (!last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  pee_value_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_value_stack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (vcmd),
    .count_o  (v_count),
    .top_o    (v_top),
    .second_o (v_second)
  );

  pee_oper_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_oper_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (ocmd),
    .count_o (o_count),
    .top_o   (o_top)
  );

  always_comb begin
    dec         = pee_pkg::decode_char(char_q);
    merged      = pee_pkg::combine(o_top, v_second, v_top);
    vcmd        = '0;
    ocmd        = '0;
    vcmd.data   = dec.val;
    ocmd.op     = dec.op;
    err_now     = 1'b0;
    nv_count    = v_count;
    nv_top      = v_top;
    if (advance) begin
      case (dec.cls)
        pee_pkg::CLS_VALUE: begin
          if (v_count == CW'(STACK_DEPTH)) begin
            err_now = 1'b1;
          end else begin
            vcmd.push = 1'b1;
            nv_count  = v_count + CW'(1);
            nv_top    = dec.val;
          end
        end
        pee_pkg::CLS_CLOSE: begin
          if (v_count < CW'(2) || o_count == '0) begin
            err_now = 1'b1;
          end else begin
            vcmd.reduce = 1'b1;
            vcmd.data   = merged;
            ocmd.pop    = 1'b1;
            nv_count    = v_count - CW'(1);
            nv_top      = merged;
          end
        end
        pee_pkg::CLS_OPER: begin
          if (o_count == CW'(STACK_DEPTH)) begin
            err_now = 1'b1;
          end else begin
            ocmd.push = 1'b1;
          end
        end
        default: begin
        end
      endcase
      vcmd.clear = last_q;
      ocmd.clear = last_q;
    end
    bad = err_q || err_now || (nv_count == '0);
    if (nv_count == '0) begin
      nv_top = pee_pkg::PAIR_ZERO;
    end
    out_data_d = {bad, nv_top[1], nv_top[0], nv_top[0] ^ nv_top[1]};
    err_d = err_q;
    if (advance) begin
      err_d = last_q ? 1'b0 : (err_q || err_now);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      err_q <= err_d;
      if (advance && last_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o) begin
      char_q <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
    if (advance && last_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_data_q};

  a_err_cleared_after_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && last_q) |=> !err_q
  ) else $error("error flag not cleared after a final character");

  a_count_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (v_count <= CW'(STACK_DEPTH)) && (o_count <= CW'(STACK_DEPTH))
  ) else $error("stack count beyond depth");

  a_input_held : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(char_q) && $stable(last_q))
  ) else $error("held input item changed while blocked");

  a_result_from_final : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(in_valid_q && last_q)
  ) else $error("result raised without a final character");

endmodule

>>> tb/tb.sv
// Self-checking bench for paren_expr_dual_evaluator_unit: character streams with random
// pacing on both sides, every result checked against a local two-lane stack evaluator.
// Depends on pee_pkg and the evaluator RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned ITEM_GOAL  = 1900;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } char_item_t;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_data   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_data;

  char_item_t char_q[$];
  logic [7:0] expr_q[$];
  logic [7:0] result_q[$];

  pee_pkg::pair_t val_stk[pee_pkg::STACK_DEPTH];
  pee_pkg::op_e   op_stk[pee_pkg::STACK_DEPTH];
  int    val_cnt  = 0;
  int    op_cnt   = 0;
  bit    err_flag = 1'b0;

  int    in_gap = 0, out_stall = 0;
  bit    in_calm = 1'b0, out_calm = 1'b0;
  int    idle_cycles = 0;
  int    errors = 0, n_chars = 0, n_results = 0, n_bad = 0, n_diff = 0, n_ovf = 0;

  paren_expr_dual_evaluator_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),   // [7:0] char_code
    .s_axis_tlast_i  (in_last),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)   // [0] result_differs, [1] value_x_low,
                                  // [2] value_x_high, [3] malformed, [7:4] zero
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit is_syntax(input logic [7:0] c);
    return c inside {pee_pkg::CH_ZERO, pee_pkg::CH_ONE, pee_pkg::CH_LOW_X,
                     pee_pkg::CH_UP_X, pee_pkg::CH_OPEN, pee_pkg::CH_CLOSE};
  endfunction

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 3))
      0: return pee_pkg::CH_ZERO;
      1: return pee_pkg::CH_ONE;
      2: return pee_pkg::CH_LOW_X;
      default: return pee_pkg::CH_UP_X;
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    logic [7:0] c;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: return pee_pkg::CH_AND;
      6, 7, 8, 9, 10: return pee_pkg::CH_OR;
      11, 12, 13, 14, 15, 16: return pee_pkg::CH_XOR;
      default: begin
        c = 8'($urandom_range(0, 255));
        while (is_syntax(c)) c = 8'($urandom_range(0, 255));
        return c;
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_noise();
    if ($urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 2))
        0: return rand_operand();
        1: return rand_operator();
        default: return $urandom_range(0, 1) ? pee_pkg::CH_OPEN : pee_pkg::CH_CLOSE;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic gen_expr(input int lvl);
    if (lvl == 0 || $urandom_range(0, 1) == 0) begin
      expr_q.push_back(rand_operand());
    end else begin
      expr_q.push_back(pee_pkg::CH_OPEN);
      gen_expr(lvl - 1);
      expr_q.push_back(rand_operator());
      gen_expr(lvl - 1);
      expr_q.push_back(pee_pkg::CH_CLOSE);
    end
  endtask

  task automatic emit_expr();
    char_item_t it;
    foreach (expr_q[i]) begin
      it.ch  = expr_q[i];
      it.fin = (i == expr_q.size() - 1);
      char_q.push_back(it);
    end
    expr_q.delete();
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
  endtask

  task automatic push_val(input pee_pkg::pair_t v);
    if (val_cnt >= pee_pkg::STACK_DEPTH) begin
      err_flag = 1'b1;
      n_ovf++;
    end else begin
      val_stk[val_cnt] = v;
      val_cnt++;
    end
  endtask

  task automatic push_op(input pee_pkg::op_e op);
    if (op_cnt >= pee_pkg::STACK_DEPTH) begin
      err_flag = 1'b1;
      n_ovf++;
    end else begin
      op_stk[op_cnt] = op;
      op_cnt++;
    end
  endtask

  task automatic eval_char(input logic [7:0] ch, input logic fin);
    pee_pkg::pair_t lhs, rhs, top;
    pee_pkg::op_e   op;
    logic           bad;
    case (ch)
      pee_pkg::CH_ZERO:  push_val(pee_pkg::PAIR_ZERO);
      pee_pkg::CH_ONE:   push_val(pee_pkg::PAIR_ONE);
      pee_pkg::CH_LOW_X: push_val(pee_pkg::PAIR_LOW_X);
      pee_pkg::CH_UP_X:  push_val(pee_pkg::PAIR_UP_X);
      pee_pkg::CH_OPEN:  ;
      pee_pkg::CH_CLOSE: begin
        if (val_cnt < 2 || op_cnt < 1) begin
          err_flag = 1'b1;
        end else begin
          rhs = val_stk[val_cnt - 1];
          lhs = val_stk[val_cnt - 2];
          op  = op_stk[op_cnt - 1];
          op_cnt--;
          val_cnt--;
          case (op)
            pee_pkg::OP_AND: val_stk[val_cnt - 1] = lhs & rhs;
            pee_pkg::OP_OR:  val_stk[val_cnt - 1] = lhs | rhs;
            pee_pkg::OP_XOR: val_stk[val_cnt - 1] = lhs ^ rhs;
            default:         val_stk[val_cnt - 1] = pee_pkg::PAIR_ZERO;
          endcase
        end
      end
      pee_pkg::CH_AND: push_op(pee_pkg::OP_AND);
      pee_pkg::CH_OR:  push_op(pee_pkg::OP_OR);
      pee_pkg::CH_XOR: push_op(pee_pkg::OP_XOR);
      default:         push_op(pee_pkg::OP_OTHER);
    endcase
    if (fin) begin
      top = (val_cnt == 0) ? pee_pkg::PAIR_ZERO : val_stk[val_cnt - 1];
      bad = err_flag || (val_cnt == 0);
      result_q.push_back({4'b0000, bad, top[1], top[0], top[1] ^ top[0]});
      val_cnt  = 0;
      op_cnt   = 0;
      err_flag = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_chars
    char_item_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= 8'h00;
      in_last  <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0 || char_q.size() == 0) begin
        in_valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        nxt = char_q.pop_front();
        in_valid <= 1'b1;
        in_data  <= nxt.ch;
        in_last  <= nxt.fin;
        in_gap   <= pick_gap(in_calm);
        if ($urandom_range(0, 99) == 0) in_calm <= !in_calm;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
      out_stall <= pick_gap(out_calm);
      if ($urandom_range(0, 99) == 0) out_calm <= !out_calm;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) begin
      n_chars++;
      eval_char(in_data, in_last);
    end
  end

  always @(posedge clk_i) begin : check_results
    logic [7:0] want;
    if (rst_ni && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result item %h", $realtime, out_data);
      end else begin
        want = result_q.pop_front();
        n_results++;
        if (want[3]) n_bad++;
        if (want[0]) n_diff++;
        if (out_data !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result mismatch: expected differs=%b low=%b high=%b malformed=%b pad=%h",
                     $realtime, want[0], want[1], want[2], want[3], want[7:4]);
            $display("  got differs=%b low=%b high=%b malformed=%b pad=%h",
                     out_data[0], out_data[1], out_data[2], out_data[3], out_data[7:4]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("paren_expr_dual_evaluator_unit test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int kind, n, pos;
    put_str("(x^X)");
    emit_expr();
    put_str("(1&x)");
    emit_expr();
    put_str("(0|X)");
    emit_expr();
    put_str("(1");
    expr_q.push_back(8'hFF);
    put_str("1)");
    emit_expr();
    expr_q.push_back(8'h00);
    emit_expr();
    expr_q.push_back(pee_pkg::CH_CLOSE);
    emit_expr();
    put_str("10");
    emit_expr();

    while (char_q.size() < ITEM_GOAL) begin
      kind = $urandom_range(0, 99);
      if (kind < 68) begin
        gen_expr($urandom_range(1, 6));
      end else if (kind < 78) begin
        n = $urandom_range(24, 34);
        repeat (n) begin
          expr_q.push_back(pee_pkg::CH_OPEN);
          expr_q.push_back(rand_operand());
          expr_q.push_back(rand_operator());
        end
        expr_q.push_back(rand_operand());
        repeat (n) expr_q.push_back(pee_pkg::CH_CLOSE);
      end else if (kind < 88) begin
        gen_expr($urandom_range(1, 5));
        pos = $urandom_range(0, expr_q.size() - 1);
        case ($urandom_range(0, 2))
          0: expr_q.delete(pos);
          1: expr_q[pos] = rand_noise();
          default: expr_q.insert(pos, rand_noise());
        endcase
        if (expr_q.size() == 0) expr_q.push_back(rand_noise());
      end else if (kind < 95) begin
        repeat ($urandom_range(1, 12)) expr_q.push_back(rand_noise());
      end else begin
        n = $urandom_range(30, 40);
        if ($urandom_range(0, 1)) repeat (n) expr_q.push_back(rand_operand());
        else repeat (n) expr_q.push_back(rand_operator());
      end
      emit_expr();
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i); while (char_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (10) @(negedge clk_i);

    $display("Checked %0d results from %0d characters: %0d malformed, %0d with lanes differing.",
             n_results, n_chars, n_bad, n_diff);
    $display("Dropped pushes on a full stack: %0d; mismatches: %0d.", n_ovf, errors);
    if (errors == 0)
      $display("paren_expr_dual_evaluator_unit test passed");
    else
      $display("paren_expr_dual_evaluator_unit test failed");
    $finish;
  end

endmodule
